@@ rtl/napt_pkg.sv @@
package napt_pkg;

  localparam int TABLE_ENTRIES_DEF     = 64;
  localparam int FIRST_PUBLIC_PORT_DEF = 20000;

  localparam int KEY_W  = 48;
  localparam int IP_W   = 32;
  localparam int PORT_W = 16;

  // request direction
  localparam logic CMD_OUTBOUND = 1'b0;
  localparam logic CMD_INBOUND  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_NEW      = 2'd1;
  localparam logic [1:0] ST_NO_MATCH = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_NO_HIT,
    S_IN_DATA
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_inc;
    logic rd_scan;
    logic rd_slot;
    logic fin_hit_scan;
    logic fin_hit_slot;
    logic fin_miss;
    logic fin_full;
    logic fin_insert;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic inbound;
    logic count_zero;
    logic slot_ok;
    logic scan_last;
    logic key_match;
    logic table_full;
  } dp_stat_t;

endpackage

@@ rtl/napt_ctrl.sv @@
module napt_ctrl
  import napt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output logic     busy,
  output dp_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.inbound) begin
          state_nxt = stat.slot_ok ? S_IN_DATA : S_IDLE;
        end else begin
          state_nxt = stat.count_zero ? S_NO_HIT : S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (stat.key_match) state_nxt = S_IDLE;
        else if (stat.scan_last) state_nxt = S_NO_HIT;
        else state_nxt = S_SCAN_RD;
      end
      S_NO_HIT:  state_nxt = S_IDLE;
      S_IN_DATA: state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd  = '0;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
      end
      S_DISPATCH: begin
        if (stat.inbound) begin
          cmd.rd_slot  = stat.slot_ok;
          cmd.fin_miss = !stat.slot_ok;
        end else begin
          cmd.scan_clr = 1'b1;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
      end
      S_SCAN_CMP: begin
        cmd.fin_hit_scan = stat.key_match;
        cmd.scan_inc     = !stat.key_match && !stat.scan_last;
      end
      S_NO_HIT: begin
        cmd.fin_full   = stat.table_full;
        cmd.fin_insert = !stat.table_full;
      end
      S_IN_DATA: begin
        cmd.fin_hit_slot = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ rtl/napt_dp.sv @@
module napt_dp
  import napt_pkg::*;
#(
  parameter int TABLE_ENTRIES     = TABLE_ENTRIES_DEF,
  parameter int FIRST_PUBLIC_PORT = FIRST_PUBLIC_PORT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic              in_command,
  input  logic [IP_W-1:0]   in_key_ip,
  input  logic [PORT_W-1:0] in_key_port,
  input  logic              cfg_valid,
  input  logic [IP_W-1:0]   cfg_data,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [IP_W-1:0]   out_mapped_ip,
  output logic [PORT_W-1:0] out_mapped_port
);

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [PORT_W-1:0] FIRST_PORT = PORT_W'(FIRST_PUBLIC_PORT);
  localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(TABLE_ENTRIES);

  logic [KEY_W-1:0]  mem [TABLE_ENTRIES];
  logic [KEY_W-1:0]  rd_data_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_en;

  logic              req_cmd_r;
  logic [KEY_W-1:0]  req_key_r;
  logic [IP_W-1:0]   public_ip_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  scan_idx_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [IP_W-1:0]   out_ip_r;
  logic [PORT_W-1:0] out_port_r;

  logic [PORT_W-1:0] slot;
  logic [PORT_W-1:0] scan_port;
  logic [PORT_W-1:0] new_port;

  // inbound slot and public ports of scan and insert positions
  assign slot      = req_key_r[PORT_W-1:0] - FIRST_PORT;
  assign scan_port = FIRST_PORT + PORT_W'(scan_idx_r);
  assign new_port  = FIRST_PORT + PORT_W'(count_r);

  assign rd_en   = cmd.rd_scan || cmd.rd_slot;
  assign rd_addr = cmd.rd_slot ? slot[IDX_W-1:0] : scan_idx_r[IDX_W-1:0];

  // status toward the controller
  always_comb begin
    stat.inbound    = (req_cmd_r == CMD_INBOUND);
    stat.count_zero = (count_r == '0);
    stat.slot_ok    = (req_key_r[KEY_W-1:PORT_W] == public_ip_r) &&
                      (slot < PORT_W'(count_r));
    stat.scan_last  = ((scan_idx_r + 1'b1) == count_r);
    stat.key_match  = (rd_data_r == req_key_r);
    stat.table_full = (count_r == FULL_COUNT);
  end

  // key table, registered read
  always_ff @(posedge clk) begin
    if (cmd.fin_insert) begin
      mem[count_r[IDX_W-1:0]] <= req_key_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd_r <= in_command;
      req_key_r <= {in_key_ip, in_key_port};
    end
  end

  // public ip, fill count and scan index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      public_ip_r <= '0;
      count_r     <= '0;
      scan_idx_r  <= '0;
    end else begin
      if (cfg_valid) begin
        public_ip_r <= cfg_data;
        count_r     <= '0;
      end else if (cmd.fin_insert) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.scan_clr) scan_idx_r <= '0;
      else if (cmd.scan_inc) scan_idx_r <= scan_idx_r + 1'b1;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin_hit_scan || cmd.fin_hit_slot || cmd.fin_miss ||
                     cmd.fin_full || cmd.fin_insert;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.fin_hit_scan) begin
      out_status_r <= ST_HIT;
      out_ip_r     <= public_ip_r;
      out_port_r   <= scan_port;
    end else if (cmd.fin_hit_slot) begin
      out_status_r <= ST_HIT;
      out_ip_r     <= rd_data_r[KEY_W-1:PORT_W];
      out_port_r   <= rd_data_r[PORT_W-1:0];
    end else if (cmd.fin_insert) begin
      out_status_r <= ST_NEW;
      out_ip_r     <= public_ip_r;
      out_port_r   <= new_port;
    end else if (cmd.fin_full) begin
      out_status_r <= ST_FULL;
      out_ip_r     <= '0;
      out_port_r   <= '0;
    end else if (cmd.fin_miss) begin
      out_status_r <= ST_NO_MATCH;
      out_ip_r     <= '0;
      out_port_r   <= '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_mapped_ip   = out_ip_r;
  assign out_mapped_port = out_port_r;

endmodule

@@ rtl/napt_translation_table.sv @@
// inbound: a hit reads the key table once at its slot (DISPATCH, IN_DATA); a miss ends in DISPATCH
// outbound: SCAN_RD and SCAN_CMP per stored entry examined; a new entry or full ends in NO_HIT
// throughput: one request at a time; the next is taken in the cycle out_valid shows
// the outbound scan examines stored entries in turn over the single read port of the key table
// reset: synchronous active-low rst_n clears state, fill count and public ip to zero
// results are strobed for one cycle; the receiver cannot stall
module napt_translation_table
  import napt_pkg::*;
#(
  parameter int TABLE_ENTRIES     = TABLE_ENTRIES_DEF,
  parameter int FIRST_PUBLIC_PORT = FIRST_PUBLIC_PORT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_command,
  input  logic [IP_W-1:0]   in_key_ip,
  input  logic [PORT_W-1:0] in_key_port,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [IP_W-1:0]   out_mapped_ip,
  output logic [PORT_W-1:0] out_mapped_port,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IP_W-1:0]   cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     start_ok;

  // config writes taken only while idle
  assign cfg_ready = !busy;
  assign start_ok  = start && !busy;

  napt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_ok),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  napt_dp #(
    .TABLE_ENTRIES     (TABLE_ENTRIES),
    .FIRST_PUBLIC_PORT (FIRST_PUBLIC_PORT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (in_command),
    .in_key_ip       (in_key_ip),
    .in_key_port     (in_key_port),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_mapped_ip   (out_mapped_ip),
    .out_mapped_port (out_mapped_port)
  );

endmodule
